FILE: rtl/fle_pkg.sv
// Shared types and constants for the FIFO exclusive lock table.
// No dependencies; used by fifo_exclusive_lock_table.
`default_nettype none

package fle_pkg;

	// Fixed field widths and the key and transaction spaces they span
	localparam int KEY_BITS = 8;
	localparam int TXN_BITS = 6;
	localparam int NUM_KEYS = 1 << KEY_BITS;
	localparam int NUM_TXNS = 1 << TXN_BITS;

	// Operation codes
	localparam logic OP_LOCK    = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_FULL       = 2'd1;
	localparam logic [1:0] STATUS_NOT_HOLDER = 2'd2;

	typedef struct packed {
		logic                op;
		logic [TXN_BITS-1:0] txn_id;
		logic [KEY_BITS-1:0] key_id;
	} req_t;

	typedef struct packed {
		logic                granted;
		logic [1:0]          status;
		logic                ready_valid;
		logic [TXN_BITS-1:0] ready_txn;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_META,
		ST_HEAD,
		ST_NEXT,
		ST_WAIT
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/fle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module fle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fifo_exclusive_lock_table.sv
// Lock table with a FIFO wait queue per key and a wait counter per transaction.
// Depends on fle_pkg and fle_ram.
//
// Takes one item at a time. A lock request ends after the key metadata read;
// a release ends there for an empty key, after the queue-head read when the
// releaser is not the holder or the queue is now empty, and otherwise goes on
// to read the new head's wait count and update it, a chain of reads in the key
// metadata, queue and wait-count memories. A result waits in an output
// register, so the block finishes the next item's work as far as its result
// while the previous result is still untaken. No clearing pass: metadata and
// wait counters carry valid bits that reset clears at once.
`default_nettype none

module fifo_exclusive_lock_table #(
	parameter int QUEUE_DEPTH = 8,
	parameter int WAIT_BITS   = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire fle_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output fle_pkg::rsp_t      rsp
);

	localparam int HB     = $clog2(QUEUE_DEPTH);
	localparam int CB     = $clog2(QUEUE_DEPTH + 1);
	localparam int MW     = HB + CB;
	localparam int QWORDS = fle_pkg::NUM_KEYS << HB;
	localparam int KB     = fle_pkg::KEY_BITS;
	localparam int TB     = fle_pkg::TXN_BITS;

	fle_pkg::state_t state_q, state_d;
	fle_pkg::req_t   item_q;
	fle_pkg::rsp_t   rsp_q, res;
	logic            rsp_valid_q;
	logic [HB-1:0]   head_q;
	logic [CB-1:0]   cnt_q;
	logic [TB-1:0]   wait_addr_q;
	logic [fle_pkg::NUM_KEYS-1:0] meta_vld_q;
	logic [fle_pkg::NUM_TXNS-1:0] wait_vld_q;

	// Memory ports
	logic              meta_we, meta_re;
	logic [KB-1:0]     meta_raddr;
	logic [MW-1:0]     meta_wdata, meta_rdata;
	logic              q_we, q_re;
	logic [KB+HB-1:0]  q_waddr, q_raddr;
	logic [TB-1:0]     q_rdata;
	logic              w_we, w_re;
	logic [TB-1:0]     w_waddr, w_raddr;
	logic [WAIT_BITS-1:0] w_wdata, w_rdata;

	// Decode
	logic              accept, out_free, done, advance;
	logic [MW-1:0]     meta_cur;
	logic [HB-1:0]     head_cur;
	logic [CB-1:0]     cnt_cur;
	logic [CB:0]       slot_sum;
	logic [HB-1:0]     slot;
	logic              full;
	logic              match;
	logic [HB-1:0]     head_nxt;
	logic [CB-1:0]     cnt_nxt;
	logic [WAIT_BITS-1:0] wait_lock, wait_next;

	fle_ram #(.WIDTH(MW), .DEPTH(fle_pkg::NUM_KEYS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(item_q.key_id), .wdata(meta_wdata),
		.re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
	);

	fle_ram #(.WIDTH(TB), .DEPTH(QWORDS)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(item_q.txn_id),
		.re(q_re), .raddr(q_raddr), .rdata(q_rdata)
	);

	fle_ram #(.WIDTH(WAIT_BITS), .DEPTH(fle_pkg::NUM_TXNS)) u_wait (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.re(w_re), .raddr(w_raddr), .rdata(w_rdata)
	);

	assign req_ready = (state_q == fle_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Decode key metadata and queue positions; unwritten entries read as zero
	always_comb begin
		meta_cur  = meta_vld_q[item_q.key_id] ? meta_rdata : '0;
		head_cur  = meta_cur[MW-1:CB];
		cnt_cur   = meta_cur[CB-1:0];
		full      = (cnt_cur >= CB'(QUEUE_DEPTH));
		slot_sum  = (CB+1)'(head_cur) + (CB+1)'(cnt_cur);
		if (slot_sum >= (CB+1)'(QUEUE_DEPTH)) begin
			slot = HB'(slot_sum - (CB+1)'(QUEUE_DEPTH));
		end else begin
			slot = HB'(slot_sum);
		end
		match     = (q_rdata == item_q.txn_id);
		head_nxt  = (head_q == HB'(QUEUE_DEPTH - 1)) ? '0 : head_q + HB'(1);
		cnt_nxt   = cnt_q - CB'(1);
		wait_lock = wait_vld_q[item_q.txn_id] ? w_rdata : '0;
		wait_next = wait_vld_q[wait_addr_q] ? w_rdata : '0;
	end

	// Work out whether the current state ends the item
	always_comb begin
		case (state_q)
			fle_pkg::ST_META: done = (item_q.op == fle_pkg::OP_LOCK) || (cnt_cur == '0);
			fle_pkg::ST_HEAD: done = !match || (cnt_nxt == '0);
			fle_pkg::ST_WAIT: done = 1'b1;
			default:          done = 1'b0;
		endcase
		advance = !(done && !out_free);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fle_pkg::ST_IDLE: begin
				if (req_valid) state_d = fle_pkg::ST_META;
			end
			fle_pkg::ST_META: begin
				if (advance) state_d = done ? fle_pkg::ST_IDLE : fle_pkg::ST_HEAD;
			end
			fle_pkg::ST_HEAD: begin
				if (advance) state_d = done ? fle_pkg::ST_IDLE : fle_pkg::ST_NEXT;
			end
			fle_pkg::ST_NEXT: state_d = fle_pkg::ST_WAIT;
			fle_pkg::ST_WAIT: begin
				if (advance) state_d = fle_pkg::ST_IDLE;
			end
			default: state_d = fle_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and result
	always_comb begin
		meta_we    = 1'b0;
		meta_re    = 1'b0;
		meta_raddr = req.key_id;
		meta_wdata = {head_cur, cnt_cur + CB'(1)};
		q_we       = 1'b0;
		q_waddr    = {item_q.key_id, slot};
		q_re       = 1'b0;
		q_raddr    = {item_q.key_id, head_cur};
		w_we       = 1'b0;
		w_waddr    = item_q.txn_id;
		w_wdata    = wait_lock + WAIT_BITS'(1);
		w_re       = 1'b0;
		w_raddr    = req.txn_id;
		res        = '0;
		res.status = fle_pkg::STATUS_OK;
		case (state_q)
			fle_pkg::ST_IDLE: begin
				meta_re = accept;
				w_re    = accept;
			end
			fle_pkg::ST_META: begin
				if (item_q.op == fle_pkg::OP_LOCK) begin
					if (full) begin
						res.status = fle_pkg::STATUS_FULL;
					end else begin
						q_we    = advance;
						meta_we = advance;
						if (cnt_cur == '0) begin
							res.granted = 1'b1;
						end else begin
							// Saturating wait count
							w_we = advance && (wait_lock != {WAIT_BITS{1'b1}});
						end
					end
				end else if (cnt_cur == '0) begin
					res.status = fle_pkg::STATUS_NOT_HOLDER;
				end else begin
					q_re = 1'b1;
				end
			end
			fle_pkg::ST_HEAD: begin
				if (!match) begin
					res.status = fle_pkg::STATUS_NOT_HOLDER;
				end else begin
					// Pop the head and look up the new one
					meta_we    = advance;
					meta_wdata = {head_nxt, cnt_nxt};
					q_raddr    = {item_q.key_id, head_nxt};
					q_re       = (cnt_nxt != '0);
				end
			end
			fle_pkg::ST_NEXT: begin
				w_raddr = q_rdata;
				w_re    = 1'b1;
			end
			fle_pkg::ST_WAIT: begin
				w_waddr = wait_addr_q;
				w_wdata = wait_next - WAIT_BITS'(1);
				w_we    = advance && (wait_next != '0);
				if (wait_next == WAIT_BITS'(1)) begin
					res.ready_valid = 1'b1;
					res.ready_txn   = wait_addr_q;
				end
			end
			default: ;
		endcase
	end

	// Control state, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fle_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			meta_vld_q  <= '0;
			wait_vld_q  <= '0;
		end else begin
			state_q <= state_d;
			if (meta_we) meta_vld_q[item_q.key_id] <= 1'b1;
			if (w_we)    wait_vld_q[w_waddr]       <= 1'b1;
			if (done && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) item_q <= req;
		if (state_q == fle_pkg::ST_META) begin
			head_q <= head_cur;
			cnt_q  <= cnt_cur;
		end
		if (state_q == fle_pkg::ST_NEXT) wait_addr_q <= q_rdata;
		if (done && out_free) rsp_q <= res;
	end

	// Checks
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.granted |-> rsp_q.status == fle_pkg::STATUS_OK)
		else $error("granted result with error status");

	a_ready_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.ready_valid |-> !rsp_q.granted &&
		rsp_q.status == fle_pkg::STATUS_OK)
		else $error("ready transaction reported on a non-release result");

	a_accept_meta: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == fle_pkg::ST_META)
		else $error("accepted item did not start metadata lookup");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(meta_we || q_we || w_we) |-> state_q != fle_pkg::ST_IDLE)
		else $error("memory write while idle");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_free |=> $stable(rsp_q))
		else $error("result register changed while stalled");

endmodule

`default_nettype wire
